// ----- sv/rgb_to_hsl_converter_top_defines.svh -----
// Assertion macros used by the RGB to HSL converter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RHC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rhc_pkg.sv -----
// Types, widths and constants for the RGB to HSL converter.
// No dependencies; imported by every RTL module of the block.
package rhc_pkg;

	localparam int CH_W    = 8;
	localparam int HUE_W   = 15;
	localparam int SAT_W   = 16;
	localparam int LSUM_W  = 9;
	localparam int NUM_W   = 24;
	localparam int QUO_W   = 16;
	localparam int DEN_W   = 8;
	localparam int K_W     = 11;
	localparam int KS_W    = 12;

	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = QUO_W / DIV_BITS;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [NUM_W-1:0]  HUE_PER_SECTOR = 24'd3840;
	localparam logic [NUM_W-1:0]  SAT_SCALE      = 24'd65535;
	localparam logic [HUE_W-1:0]  HUE_FULL_TURN  = 15'd23040;
	localparam logic [LSUM_W-1:0] LSUM_MAX       = 9'd510;
	localparam logic [LSUM_W-1:0] LSUM_MID       = 9'd255;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  saturation;
		logic [LSUM_W-1:0] lightness_sum;
	} hsl_t;

	typedef struct packed {
		logic [NUM_W-1:0]  hue_num;
		logic [DEN_W-1:0]  hue_den;
		logic [NUM_W-1:0]  sat_num;
		logic [DEN_W-1:0]  sat_den;
		logic [LSUM_W-1:0] lightness_sum;
	} work_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] nq;
		logic [DEN_W-1:0] den;
	} div_lane_t;

	typedef struct packed {
		div_lane_t         hue;
		div_lane_t         sat;
		logic [LSUM_W-1:0] lightness_sum;
	} div_stage_t;

endpackage

// ----- sv/rgb_to_hsl_converter_top.sv -----
// Path from an accepted rgb beat to its hsl beat: front register, queue slot,
// then 8 divider stages of 2 quotient bits each.
// Throughput: one pixel per cycle while hsl_ready is held high, set by the fully pipelined divider lanes.
// Reset: arst_n clears all valid flags and queue pointers; no pass needed.
// Depends on rhc_pkg, rhc_front, rhc_queue, rhc_back and the defines header.
`include "rgb_to_hsl_converter_top_defines.svh"

module rgb_to_hsl_converter_top import rhc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  rgb_t rgb,
	input  logic rgb_valid,
	output logic rgb_ready,
	output hsl_t hsl,
	output logic hsl_valid,
	input  logic hsl_ready
);

	work_t f_work, q_work;
	logic  f_valid, f_ready, q_valid, q_ready;

	rhc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rgb        (rgb),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.work       (f_work),
		.work_valid (f_valid),
		.work_ready (f_ready)
	);

	rhc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (f_work),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_data   (q_work),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	rhc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (q_work),
		.work_valid (q_valid),
		.work_ready (q_ready),
		.hsl        (hsl),
		.hsl_valid  (hsl_valid),
		.hsl_ready  (hsl_ready)
	);

	`RHC_ASSERT_IMPLY(a_hue_range, clk, arst_n, hsl_valid, hsl.hue < HUE_FULL_TURN, "hue out of range")
	`RHC_ASSERT_IMPLY(a_sat_extreme, clk, arst_n,
		hsl_valid && (hsl.lightness_sum == '0 || hsl.lightness_sum == LSUM_MAX),
		hsl.saturation == '0, "nonzero saturation on black or white")
	`RHC_ASSERT_IMPLY(a_grey_hue, clk, arst_n, hsl_valid && hsl.saturation == '0,
		hsl.hue == '0, "zero saturation with nonzero hue")
	`RHC_ASSERT_NEXT(a_lsum_hold, clk, arst_n, hsl_valid && !hsl_ready,
		hsl_valid && $stable(hsl.lightness_sum), "stalled result changed")

endmodule

// ----- sv/rhc_front.sv -----
// Front end: accepts RGB beats, finds max/min/chroma and the hue sector,
// and registers dividend/divisor pairs for the back end. Uses rhc_pkg.
module rhc_front import rhc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  rgb_t  rgb,
	input  logic  rgb_valid,
	output logic  rgb_ready,
	output work_t work,
	output logic  work_valid,
	input  logic  work_ready
);

	logic [CH_W-1:0]   mx, mn, c, dv;
	logic [LSUM_W-1:0] sum, dv_full;
	logic signed [KS_W-1:0] r_s, g_s, b_s, c_s, k_s;
	work_t w;
	work_t work_s1;
	logic  v_s1;

	always_comb begin
		mx = rgb.red;
		if (rgb.green > mx) mx = rgb.green;
		if (rgb.blue > mx) mx = rgb.blue;
		mn = rgb.red;
		if (rgb.green < mn) mn = rgb.green;
		if (rgb.blue < mn) mn = rgb.blue;
		c   = mx - mn;
		sum = {1'b0, mx} + {1'b0, mn};

		r_s = signed'(KS_W'(rgb.red));
		g_s = signed'(KS_W'(rgb.green));
		b_s = signed'(KS_W'(rgb.blue));
		c_s = signed'(KS_W'(c));

		// hue numerator in sector units; red wins ties, then green
		if (mx == rgb.red) begin
			if (rgb.green >= rgb.blue) k_s = g_s - b_s;
			else k_s = 12'sd6 * c_s - (b_s - g_s);
		end else if (mx == rgb.green) begin
			k_s = 12'sd2 * c_s + b_s - r_s;
		end else begin
			k_s = 12'sd4 * c_s + r_s - g_s;
		end

		dv_full = (sum <= LSUM_MID) ? sum : LSUM_MAX - sum;
		dv      = dv_full[CH_W-1:0];

		// zero divisor: numerator is zero too, divide by one gives zero
		w.hue_num       = NUM_W'(k_s[K_W-1:0]) * HUE_PER_SECTOR;
		w.hue_den       = (c == '0) ? DEN_W'(1) : c;
		w.sat_num       = NUM_W'(c) * SAT_SCALE;
		w.sat_den       = (dv == '0) ? DEN_W'(1) : dv;
		w.lightness_sum = sum;
	end

	assign rgb_ready  = !v_s1 || work_ready;
	assign work       = work_s1;
	assign work_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rgb_valid && rgb_ready) begin
			v_s1 <= 1'b1;
		end else if (work_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rgb_valid && rgb_ready) begin
			work_s1 <= w;
		end
	end

endmodule

// ----- sv/rhc_queue.sv -----
// Short FIFO of work beats between front and back ends.
// Register storage, one read port at the head. Uses rhc_pkg.
module rhc_queue import rhc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  work_t push_data,
	input  logic  push_valid,
	output logic  push_ready,
	output work_t pop_data,
	output logic  pop_valid,
	input  logic  pop_ready
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	work_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push, pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ----- sv/rhc_back.sv -----
// Back end: two pipelined restoring dividers (hue and saturation),
// DIV_BITS quotient bits per stage, last stage is the output register. Uses rhc_pkg.
module rhc_back import rhc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  work_t work,
	input  logic  work_valid,
	output logic  work_ready,
	output hsl_t  hsl,
	output logic  hsl_valid,
	input  logic  hsl_ready
);

	localparam int LAST = DIV_STAGES - 1;

	function automatic div_lane_t div_step(div_lane_t l);
		div_lane_t        o;
		logic [DEN_W:0]   r9;
		o = l;
		for (int i = 0; i < DIV_BITS; i++) begin
			r9 = {o.rem, o.nq[QUO_W-1]};
			if (r9 >= {1'b0, o.den}) begin
				r9    = r9 - {1'b0, o.den};
				o.nq  = {o.nq[QUO_W-2:0], 1'b1};
			end else begin
				o.nq  = {o.nq[QUO_W-2:0], 1'b0};
			end
			o.rem = r9[DEN_W-1:0];
		end
		return o;
	endfunction

	div_stage_t             stg_s [DIV_STAGES];
	logic [DIV_STAGES-1:0]  pv_s;
	div_stage_t             head;
	logic                   adv;

	assign adv        = !pv_s[LAST] || hsl_ready;
	assign work_ready = adv;

	// quotient fits in QUO_W bits, so the top dividend bits are already below den
	always_comb begin
		head.hue.rem       = work.hue_num[NUM_W-1:QUO_W];
		head.hue.nq        = work.hue_num[QUO_W-1:0];
		head.hue.den       = work.hue_den;
		head.sat.rem       = work.sat_num[NUM_W-1:QUO_W];
		head.sat.nq        = work.sat_num[QUO_W-1:0];
		head.sat.den       = work.sat_den;
		head.lightness_sum = work.lightness_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s <= '0;
		end else if (adv) begin
			pv_s <= {pv_s[DIV_STAGES-2:0], work_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s[0].hue           <= div_step(head.hue);
			stg_s[0].sat           <= div_step(head.sat);
			stg_s[0].lightness_sum <= head.lightness_sum;
			for (int i = 1; i < DIV_STAGES; i++) begin
				stg_s[i].hue           <= div_step(stg_s[i-1].hue);
				stg_s[i].sat           <= div_step(stg_s[i-1].sat);
				stg_s[i].lightness_sum <= stg_s[i-1].lightness_sum;
			end
		end
	end

	assign hsl_valid         = pv_s[LAST];
	assign hsl.hue           = stg_s[LAST].hue.nq[HUE_W-1:0];
	assign hsl.saturation    = stg_s[LAST].sat.nq[SAT_W-1:0];
	assign hsl.lightness_sum = stg_s[LAST].lightness_sum;

endmodule
